// File: rtl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;
  localparam int unsigned KernelSize   = 3;

  localparam int unsigned PixW         = 8;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned RowRegW      = 48;
  localparam int unsigned FrameWidthW  = 12;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned FiltW        = 28;
  localparam int unsigned ProdW        = PixW + 1 + CoefW;
  localparam int unsigned RowSumW      = ProdW + 2;
  localparam int unsigned InDataW      = 8;
  localparam int unsigned OutDataW     = 32;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CfgAddrW     = 6;
  localparam int unsigned CfgIdxW      = CfgAddrW - 3;

  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueLevelW  = $clog2(QueueDepth + 1);

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 13'd480;
  localparam logic [RowRegW-1:0]      KernelOuterReset = 48'h0;
  localparam logic [RowRegW-1:0]      KernelMidReset   = 48'h0000_0100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegKernelTop   = 3'd2,
    RegKernelMid   = 3'd3,
    RegKernelBot   = 3'd4
  } c2d_reg_e;

  typedef struct packed {
    logic [FrameWidthW-1:0]               frame_width;
    logic [FrameHeightW-1:0]              frame_height;
    logic [KernelSize-1:0][RowRegW-1:0]   kernel;
    logic                                 restart;
  } c2d_cfg_t;

  typedef struct packed {
    logic [KernelSize-1:0][KernelSize-1:0][PixW-1:0] pix;
    logic                                            last;
  } c2d_win_t;

endpackage

`default_nettype wire

// File: rtl/conv2d_3x3_zero_padded.sv
// Channel  Dir  Ports            Request contents
// s_axis   in   tvalid/tready    tdata[7:0] pixel
// m_axis   out  tvalid/tready    tdata[27:0] filtered (signed), tlast frame_end
// apb      in   psel..pready     64-bit registers at paddr 8*i
//
// One pixel request per clock while s_axis_tready is high. m_axis_tvalid rises
// after the request that completes its window (pixel k+width+1) has passed the
// line store read stage loaded by the accepting edge, the queue write, the
// multiply stage and the two adder stages, in that order.
// Reset clears counters, handshakes and config registers; line stores are not cleared.
// A 4-entry queue decouples window build from the MAC pipe; a stalled m_axis
// drops s_axis_tready once the queue and the read stage hold 4 requests.
`default_nettype none

module conv2d_3x3_zero_padded
  import c2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [7:0] pixel
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,  // [27:0] filtered, [31:28] zero
  output      logic                m_axis_tlast,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready
);

  c2d_cfg_t               cfg;
  c2d_win_t               push_win, head_win;
  logic                   push, pop, head_valid;
  logic [QueueLevelW-1:0] level;

  c2d_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  c2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .level_i       (level),
    .push_o        (push),
    .win_o         (push_win)
  );

  c2d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_win),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_win),
    .level_o (level)
  );

  c2d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kernel_i      (cfg.kernel),
    .valid_i       (head_valid),
    .win_i         (head_win),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/c2d_regs.sv
`default_nettype none

module c2d_regs
  import c2d_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready,
  output      c2d_cfg_t            cfg_o
);

  logic [FrameWidthW-1:0]  width_q;
  logic [FrameHeightW-1:0] height_q;
  logic [RowRegW-1:0]      ktop_q, kmid_q, kbot_q;
  logic [CfgIdxW-1:0]      idx;
  logic                    wr;

  assign idx    = paddr[CfgAddrW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthReset;
      height_q <= FrameHeightReset;
      ktop_q   <= KernelOuterReset;
      kmid_q   <= KernelMidReset;
      kbot_q   <= KernelOuterReset;
    end else if (wr) begin
      unique case (c2d_reg_e'(idx))
        RegFrameWidth:  width_q  <= pwdata[FrameWidthW-1:0];
        RegFrameHeight: height_q <= pwdata[FrameHeightW-1:0];
        RegKernelTop:   ktop_q   <= pwdata[RowRegW-1:0];
        RegKernelMid:   kmid_q   <= pwdata[RowRegW-1:0];
        RegKernelBot:   kbot_q   <= pwdata[RowRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (c2d_reg_e'(idx))
      RegFrameWidth:  prdata = CfgDataW'(width_q);
      RegFrameHeight: prdata = CfgDataW'(height_q);
      RegKernelTop:   prdata = CfgDataW'(ktop_q);
      RegKernelMid:   prdata = CfgDataW'(kmid_q);
      RegKernelBot:   prdata = CfgDataW'(kbot_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.frame_width  = width_q;
    cfg_o.frame_height = height_q;
    cfg_o.kernel[0]    = ktop_q;
    cfg_o.kernel[1]    = kmid_q;
    cfg_o.kernel[2]    = kbot_q;
    // frame restarts on the same edge as a dimension write
    cfg_o.restart      = wr && ((c2d_reg_e'(idx) == RegFrameWidth) ||
                                (c2d_reg_e'(idx) == RegFrameHeight));
  end

endmodule

`default_nettype wire

// File: rtl/c2d_front.sv
`default_nettype none

module c2d_front
  import c2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire c2d_cfg_t               cfg_i,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [InDataW-1:0]     s_axis_tdata,
  input  wire logic [QueueLevelW-1:0] level_i,
  output      logic                   push_o,
  output      c2d_win_t               win_o
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned ORW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW  = QueueLevelW + 1;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } bnd_t;

  logic [CW-1:0]  width;
  logic [RW-1:0]  height;

  logic [AW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [ORW-1:0] out_row_q, out_row_d;

  logic           accept, emit, pix_live, last, col_wrap, ocol_wrap;
  logic [CW-1:0]  col_inc, ocol_inc;
  bnd_t           bnd;

  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q, byp_data_q, line, wdata;

  logic           s1_valid_q, s1_emit_q, s1_last_q, byp_q;
  logic [PixW-1:0] s1_pix_q;
  logic [AW-1:0]  s1_addr_q;
  bnd_t           s1_bnd_q;

  logic [KernelSize-1:0][KernelSize-1:0][PixW-1:0] win_q, win_d;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      width = CW'(1);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      width = CW'(MAX_WIDTH);
    end else begin
      width = CW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      height = RW'(1);
    end else if (32'(cfg_i.frame_height) > MAX_HEIGHT) begin
      height = RW'(MAX_HEIGHT);
    end else begin
      height = RW'(cfg_i.frame_height);
    end
  end

  assign s_axis_tready = (LW'(level_i) + LW'(s1_valid_q)) < LW'(QueueDepth);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_inc    = CW'(in_col_q) + CW'(1);
    col_wrap   = col_inc >= width;
    ocol_inc   = CW'(out_col_q) + CW'(1);
    ocol_wrap  = ocol_inc >= width;
    emit       = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
    pix_live   = in_row_q < height;
    bnd.top    = out_row_q != '0;
    bnd.bottom = (RW'(out_row_q) + RW'(1)) < height;
    bnd.left   = out_col_q != '0;
    bnd.right  = ocol_inc < width;
    last       = !bnd.bottom && !bnd.right;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_i.restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      in_col_d = col_wrap ? '0 : col_inc[AW-1:0];
      in_row_d = col_wrap ? in_row_q + RW'(1) : in_row_q;
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (ocol_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORW'(1);
        end else begin
          out_col_d = ocol_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_live ? s_axis_tdata[PixW-1:0] : '0;
      s1_addr_q <= in_col_q;
      s1_emit_q <= emit;
      s1_bnd_q  <= bnd;
      s1_last_q <= last;
      // same column written this cycle: take the write data next cycle
      byp_q     <= s1_valid_q && (s1_addr_q == in_col_q);
    end
  end

  // line store word: older row in the upper byte, previous row in the lower
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wdata;
    end
    if (accept) begin
      rd_q <= line_mem[in_col_q];
    end
  end

  always_comb begin
    line  = byp_q ? byp_data_q : rd_q;
    wdata = {line[PixW-1:0], s1_pix_q};
    for (int i = 0; i < KernelSize; i++) begin
      for (int j = 0; j < KernelSize - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    win_d[0][KernelSize-1] = line[2*PixW-1:PixW];
    win_d[1][KernelSize-1] = line[PixW-1:0];
    win_d[2][KernelSize-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q      <= win_d;
      byp_data_q <= wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < KernelSize; i++) begin
      for (int j = 0; j < KernelSize; j++) begin
        if ((i == 0 && !s1_bnd_q.top) || (i == KernelSize - 1 && !s1_bnd_q.bottom) ||
            (j == 0 && !s1_bnd_q.left) || (j == KernelSize - 1 && !s1_bnd_q.right)) begin
          win_o.pix[i][j] = '0;
        end else begin
          win_o.pix[i][j] = win_d[i][j];
        end
      end
    end
    win_o.last = s1_last_q;
  end

  assign push_o = s1_valid_q && s1_emit_q;

endmodule

`default_nettype wire

// File: rtl/c2d_queue.sv
`default_nettype none

module c2d_queue
  import c2d_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire c2d_win_t               data_i,
  input  wire logic                   pop_i,
  output      logic                   valid_o,
  output      c2d_win_t               data_o,
  output      logic [QueueLevelW-1:0] level_o
);

  c2d_win_t               entries_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueLevelW-1:0] count_q;
  logic                   do_pop;

  assign valid_o = count_q != '0;
  assign data_o  = entries_q[rd_ptr_q];
  assign level_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QueueLevelW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - QueueLevelW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/c2d_back.sv
`default_nettype none

module c2d_back
  import c2d_pkg::*;
(
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [KernelSize-1:0][RowRegW-1:0] kernel_i,
  input  wire logic                               valid_i,
  input  wire c2d_win_t                           win_i,
  output      logic                               pop_o,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output      logic [OutDataW-1:0]                m_axis_tdata,
  output      logic                               m_axis_tlast
);

  logic signed [ProdW-1:0]   prod_d [KernelSize][KernelSize];
  logic signed [ProdW-1:0]   prod_q [KernelSize][KernelSize];
  logic signed [RowSumW-1:0] row_q  [KernelSize];
  logic signed [FiltW-1:0]   sum_q;
  logic                      v1_q, v2_q, v3_q;
  logic                      last1_q, last2_q, last3_q;
  logic                      adv1, adv2, adv3;

  assign adv3  = !v3_q || m_axis_tready;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign pop_o = valid_i && adv1;

  always_comb begin
    for (int i = 0; i < KernelSize; i++) begin
      for (int j = 0; j < KernelSize; j++) begin
        prod_d[i][j] = ProdW'($signed({1'b0, win_i.pix[i][j]})) *
                       ProdW'($signed(kernel_i[i][CoefW*j +: CoefW]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q  <= prod_d;
      last1_q <= win_i.last;
    end
    if (adv2 && v1_q) begin
      for (int i = 0; i < KernelSize; i++) begin
        row_q[i] <= RowSumW'(prod_q[i][0]) + RowSumW'(prod_q[i][1]) +
                    RowSumW'(prod_q[i][2]);
      end
      last2_q <= last1_q;
    end
    if (adv3 && v2_q) begin
      sum_q   <= FiltW'(row_q[0]) + FiltW'(row_q[1]) + FiltW'(row_q[2]);
      last3_q <= last2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{(OutDataW-FiltW){1'b0}}, sum_q};
  assign m_axis_tlast  = last3_q;

endmodule

`default_nettype wire
